// ===== hdl/assert_macros.svh =====
// assertion macros shared by the strip converter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/tsl_pkg.sv =====
// types and constants of the triangle strip to list converter
`timescale 1ns / 1ps

package tsl_pkg;

	localparam int unsigned VertexWidth = 16;

	// restart value after reset
	localparam logic [VertexWidth-1:0] RestartReset = 16'hFFFF;

	typedef logic [VertexWidth-1:0] vertex_t;

	// one strip index as held in the input register
	typedef struct packed {
		vertex_t vertex_index;
		logic    start_of_list;
	} strip_item_t;

	// one emitted triangle
	typedef struct packed {
		vertex_t first;
		vertex_t second;
		vertex_t third;
	} tri_t;

endpackage

// ===== hdl/triangle_strip_to_list_core.sv =====
// top level of the triangle strip to triangle list converter
`timescale 1ns / 1ps
// a triangle's closing index is held in the input register, and the triangle is then loaded into the
// result register, which raises out_valid; a stalled, full result register can hold it back in between
// throughput: one index per cycle, held back only when the result register is stalled
// the window update and triangle check sit between the input and result registers
// reset clears the window to zero, the restart value to 0xFFFF and both valid flags
`include "assert_macros.svh"

module triangle_strip_to_list_core
	import tsl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	// configuration: restart value
	input  logic    cfg_wr_en,
	input  vertex_t cfg_wr_data,
	// strip index channel
	input  logic    in_valid,
	output logic    in_stall,
	input  vertex_t vertex_index,
	input  logic    start_of_list,
	// triangle channel
	output logic    out_valid,
	input  logic    out_stall,
	output vertex_t vertex_first,
	output vertex_t vertex_second,
	output vertex_t vertex_third
);

	// input register contents
	logic        valid_s1;
	strip_item_t item_s1;

	// the held index leaves the input register whenever the result register
	// can take whatever it produces; indices with no triangle leave as well
	logic advance;
	logic out_free;

	// triangle formed from the window and the held index
	logic tri_valid;
	tri_t tri_cur;

	assign advance = valid_s1 & out_free;

	tsl_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vertex_index (vertex_index),
		.start_of_list(start_of_list),
		.advance      (advance),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	// window shift, restart detection, winding choice and degenerate drop
	tsl_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.advance    (advance),
		.item_s1    (item_s1),
		.tri_valid  (tri_valid),
		.tri_out    (tri_cur)
	);

	// result register, loaded only on a transfer that forms a triangle
	tsl_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance & tri_valid),
		.tri_in       (tri_cur),
		.free         (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex_first (vertex_first),
		.vertex_second(vertex_second),
		.vertex_third (vertex_third)
	);

	// the input side is held back only by a stalled, full result register
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall,
		valid_s1 && out_valid && out_stall,
		"input stalled without a blocked result")

endmodule

// ===== hdl/tsl_in_stage.sv =====
// input register of the strip converter
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsl_in_stage
	import tsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  vertex_t     vertex_index,
	input  logic        start_of_list,
	input  logic        advance,
	output logic        valid_s1,
	output strip_item_t item_s1
);

	logic accept;

	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.vertex_index  <= vertex_index;
			item_s1.start_of_list <= start_of_list;
		end
	end

	// an item only moves on from a filled register
	`ASSERT_IMPLY(a_advance_needs_item, clk, arst_n, advance, valid_s1,
		"advance without an item in the input register")

endmodule

// ===== hdl/tsl_window.sv =====
// two-vertex window, restart register and triangle forming
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsl_window
	import tsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  vertex_t     cfg_wr_data,
	input  logic        advance,
	input  strip_item_t item_s1,
	output logic        tri_valid,
	output tri_t        tri_out
);

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_STREAM
	} phase_t;

	phase_t  phase_q, phase_n;
	vertex_t older_q, older_n;
	vertex_t newer_q, newer_n;
	logic    parity_q, parity_n;
	vertex_t restart_q;
	vertex_t idx;
	logic    distinct;

	assign idx = item_s1.vertex_index;
	assign distinct = (older_q != newer_q) && (newer_q != idx) && (idx != older_q);

	assign tri_out.first  = older_q;
	assign tri_out.second = parity_q ? idx : newer_q;
	assign tri_out.third  = parity_q ? newer_q : idx;

	always_comb begin
		phase_n   = phase_q;
		older_n   = older_q;
		newer_n   = newer_q;
		parity_n  = parity_q;
		tri_valid = 1'b0;
		if (item_s1.start_of_list) begin
			older_n  = idx;
			parity_n = 1'b0;
			phase_n  = PH_SECOND;
		end else begin
			case (phase_q)
				PH_FIRST: begin
					older_n = idx;
					phase_n = PH_SECOND;
				end
				PH_SECOND: begin
					newer_n  = idx;
					parity_n = 1'b0;
					phase_n  = PH_STREAM;
				end
				PH_STREAM: begin
					if (idx == restart_q) begin
						phase_n  = PH_FIRST;
						parity_n = 1'b0;
					end else begin
						tri_valid = distinct;
						parity_n  = ~parity_q;
						older_n   = newer_q;
						newer_n   = idx;
					end
				end
				default: begin
					phase_n = PH_FIRST;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			older_q   <= '0;
			newer_q   <= '0;
			parity_q  <= 1'b0;
			restart_q <= RestartReset;
		end else begin
			if (cfg_wr_en) begin
				restart_q <= cfg_wr_data;
			end
			if (advance) begin
				phase_q  <= phase_n;
				older_q  <= older_n;
				newer_q  <= newer_n;
				parity_q <= parity_n;
			end
		end
	end

	// triangles come only out of the streaming phase
	`ASSERT_IMPLY(a_tri_in_stream, clk, arst_n, tri_valid,
		phase_q == PH_STREAM && !item_s1.start_of_list,
		"triangle formed outside the streaming phase")

	// an emitted triangle never carries a repeated vertex
	`ASSERT_IMPLY(a_tri_distinct, clk, arst_n, tri_valid,
		tri_out.first != tri_out.second && tri_out.second != tri_out.third
			&& tri_out.first != tri_out.third,
		"degenerate triangle not dropped")

endmodule

// ===== hdl/tsl_out_stage.sv =====
// result register of the strip converter
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsl_out_stage
	import tsl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  tri_t    tri_in,
	output logic    free,
	output logic    out_valid,
	input  logic    out_stall,
	output vertex_t vertex_first,
	output vertex_t vertex_second,
	output vertex_t vertex_third
);

	tri_t tri_s2;

	assign free = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tri_s2 <= tri_in;
		end
	end

	assign vertex_first  = tri_s2.first;
	assign vertex_second = tri_s2.second;
	assign vertex_third  = tri_s2.third;

	// a triangle is only loaded when the register can take it
	`ASSERT_PROP(a_load_when_free, clk, arst_n, load |=> out_valid,
		"loaded triangle not presented")

endmodule
